### rtl/u2u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 package
// Shared types, constants and the code point encoder for the transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // Default width of the per-string byte counter.
    localparam int COUNT_BITS_DEF = 16;

    // Depth of the job queue between the front and back ends.
    localparam int JOB_DEPTH = 4;

    // Reset value of the output room register.
    localparam logic [15:0] CAP_RESET = 16'd1024;

    // Surrogate ranges.
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    // Supplementary plane offset and the payload mask of a surrogate.
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [15:0] SURR_MASK  = 16'h03FF;

    // Sequence length thresholds and lead/continuation byte marks.
    localparam logic [20:0] LIM_ONE    = 21'h80;
    localparam logic [20:0] LIM_TWO    = 21'h800;
    localparam logic [20:0] LIM_THREE  = 21'h10000;
    localparam logic [7:0]  LEAD_TWO   = 8'hC0;
    localparam logic [7:0]  LEAD_THREE = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;

    // One queued job: the bytes of one code point, or a terminator.
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [2:0]      len;
        logic            is_end;
        logic [15:0]     base;
    } job_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Encoded form of one code point.
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [2:0]      len;
    } enc_t;

    // Build the UTF-8 bytes of one code point, first byte in seq[0].
    function automatic enc_t encode(input logic [20:0] code);
        enc_t e;
        e = '0;
        if (code < LIM_ONE) begin
            e.seq[0] = code[7:0];
            e.len    = 3'd1;
        end
        else if (code < LIM_TWO) begin
            e.seq[0] = LEAD_TWO | {3'b000, code[10:6]};
            e.seq[1] = CONT_MARK | {2'b00, code[5:0]};
            e.len    = 3'd2;
        end
        else if (code < LIM_THREE) begin
            e.seq[0] = LEAD_THREE | {4'b0000, code[15:12]};
            e.seq[1] = CONT_MARK | {2'b00, code[11:6]};
            e.seq[2] = CONT_MARK | {2'b00, code[5:0]};
            e.len    = 3'd3;
        end
        else begin
            e.seq[0] = LEAD_FOUR | {5'b00000, code[20:18]};
            e.seq[1] = CONT_MARK | {2'b00, code[17:12]};
            e.seq[2] = CONT_MARK | {2'b00, code[11:6]};
            e.seq[3] = CONT_MARK | {2'b00, code[5:0]};
            e.len    = 3'd4;
        end
        return e;
    endfunction

endpackage

### rtl/u2u8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front end
// Takes code units, pairs surrogates, checks output room and queues jobs.
// ----------------------------------------------------------------------------
module u2u8_front #(
    parameter int COUNT_BITS = u2u8_pkg::COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            code_unit,
    input  u2u8_pkg::fifo_stat_t   fifo_stat,
    output logic                   push,
    output u2u8_pkg::job_t         push_job
);

    // Compare width covers both the counter plus one and the 16-bit room.
    localparam int CW = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;
    localparam logic [CW-1:0] MASK = (CW'(1) << COUNT_BITS) - CW'(1);

    logic                  high_pending_reg, high_pending_next;
    logic [9:0]            high_bits_reg, high_bits_next;
    logic [COUNT_BITS-1:0] bytes_written_reg, bytes_written_next;
    logic                  halted_reg, halted_next;
    logic [15:0]           cap_reg;

    logic                  accept;
    logic                  is_high;
    logic                  is_low;
    logic                  do_put;
    logic [20:0]           code;
    u2u8_pkg::enc_t        enc;
    logic [CW-1:0]         sum;
    logic [31:0]           bw_wide;

    assign in_stall = fifo_stat.full;
    assign accept   = in_valid && !in_stall;
    assign bw_wide  = 32'(bytes_written_reg);

    // Classify the unit against the surrogate ranges.
    always_comb
    begin
        is_high = code_unit inside {[u2u8_pkg::HIGH_FIRST:u2u8_pkg::HIGH_LAST]};
        is_low  = code_unit inside {[u2u8_pkg::LOW_FIRST:u2u8_pkg::LOW_LAST]};
    end

    // Next state and queued job for the accepted word.
    always_comb
    begin
        high_pending_next  = high_pending_reg;
        high_bits_next     = high_bits_reg;
        bytes_written_next = bytes_written_reg;
        halted_next        = halted_reg;
        push               = 1'b0;
        push_job           = '0;
        do_put             = 1'b0;
        code               = {5'b00000, code_unit};

        if (accept) begin
            if (code_unit == 16'h0000) begin
                // Terminator carries the string total and rearms the block.
                push               = 1'b1;
                push_job.len       = 3'd1;
                push_job.is_end    = 1'b1;
                push_job.base      = bw_wide[15:0];
                high_pending_next  = 1'b0;
                high_bits_next     = '0;
                bytes_written_next = '0;
                halted_next        = 1'b0;
            end
            else if (!halted_reg) begin
                if (high_pending_reg) begin
                    high_pending_next = 1'b0;
                    if (is_low) begin
                        code   = u2u8_pkg::SUPP_BASE
                               + {1'b0, high_bits_reg,
                                  code_unit[9:0] & u2u8_pkg::SURR_MASK[9:0]};
                        do_put = 1'b1;
                    end
                    else begin
                        halted_next = 1'b1;
                    end
                end
                else if (is_high) begin
                    high_pending_next = 1'b1;
                    high_bits_next    = code_unit[9:0];
                end
                else if (is_low) begin
                    halted_next = 1'b1;
                end
                else begin
                    do_put = 1'b1;
                end
            end
        end

        // Room check: the whole sequence fits or nothing is written.
        enc = u2u8_pkg::encode(code);
        sum = CW'(bytes_written_reg) + CW'(enc.len);
        if (do_put) begin
            if (sum <= CW'(cap_reg) && sum <= MASK) begin
                push               = 1'b1;
                push_job.seq       = enc.seq;
                push_job.len       = enc.len;
                push_job.is_end    = 1'b0;
                push_job.base      = bw_wide[15:0];
                bytes_written_next = sum[COUNT_BITS-1:0];
            end
            else begin
                halted_next = 1'b1;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            high_pending_reg  <= 1'b0;
            high_bits_reg     <= '0;
            bytes_written_reg <= '0;
            halted_reg        <= 1'b0;
        end
        else begin
            high_pending_reg  <= high_pending_next;
            high_bits_reg     <= high_bits_next;
            bytes_written_reg <= bytes_written_next;
            halted_reg        <= halted_next;
        end
    end

    // Output room register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= u2u8_pkg::CAP_RESET;
        end
        else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

endmodule

### rtl/u2u8_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module u2u8_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u2u8_pkg::job_t       push_job,
    input  logic                 pop,
    output u2u8_pkg::job_t       head_job,
    output u2u8_pkg::fifo_stat_t stat
);

    localparam int DEPTH = u2u8_pkg::JOB_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    u2u8_pkg::job_t  slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == CNTW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = slots[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/u2u8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 back end
// Walks the head job one byte per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module u2u8_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u2u8_pkg::job_t       head_job,
    input  u2u8_pkg::fifo_stat_t fifo_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 is_end,
    output logic                 last,
    output logic [15:0]          byte_count
);

    logic [1:0]  pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        is_end_reg;
    logic        last_reg;
    logic [15:0] byte_count_reg;
    logic        load;
    logic        emit;
    logic        at_last;

    assign load    = !out_valid_reg || !out_stall;
    assign emit    = load && !fifo_stat.empty;
    assign at_last = ({1'b0, pos_reg} == head_job.len - 3'd1);
    assign pop     = emit && at_last;

    // Byte position within the head job and output valid.
    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            pos_next       = at_last ? 2'd0 : pos_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (load) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_byte_reg <= head_job.seq[pos_reg];
            is_end_reg   <= head_job.is_end;
            last_reg     <= at_last;
            byte_count_reg <= head_job.is_end
                            ? head_job.base
                            : head_job.base + {14'd0, pos_reg} + 16'd1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_end     = is_end_reg;
    assign last       = last_reg;
    assign byte_count = byte_count_reg;

endmodule

### rtl/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes, one byte a word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / code_unit) takes one code unit per
//   word; a zero unit ends the string. Output channel (out_valid / out_stall)
//   gives one byte per word with is_end, last and the running byte_count.
//   cfg_we / cfg_wdata set the output room per string; write it while idle.
// The first byte of a unit passes through the job queue and then the output
//   register. The output gives one byte per cycle while a job is queued and
//   out_stall is low; a unit gives 1 to 3 bytes (a surrogate pair 4 bytes for
//   its two units), and the back end's byte walk sets this output rate.
// A four-entry job queue lets the input keep flowing while bytes drain;
//   in_stall rises only when that queue is full.
// Reset clears the surrogate state, the count and the stop flag, empties the
//   queue and sets the room to 1024. A stalled output word holds steady and
//   back-pressure reaches the input once the queue fills.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
    parameter int COUNT_BITS = u2u8_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_end,
    output logic        last,
    output logic [15:0] byte_count
);

    u2u8_pkg::fifo_stat_t fifo_stat;
    u2u8_pkg::job_t       push_job;
    u2u8_pkg::job_t       head_job;
    logic                 push;
    logic                 pop;

    // Front end: classification, surrogate pairing and room check.
    u2u8_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .code_unit (code_unit),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_job  (push_job)
    );

    // Job queue between the two ends.
    u2u8_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (fifo_stat)
    );

    // Back end: byte serializer and output register.
    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .fifo_stat  (fifo_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .is_end     (is_end),
        .last       (last),
        .byte_count (byte_count)
    );

    // The front end never queues a job into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_stat.full)
        else $error("job pushed into a full queue");

    // A terminator word always closes its unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_end) |-> (last && out_byte == 8'h00))
        else $error("terminator word is not marked last");

    // Bytes of one code point follow back to back with a rising count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last)
        |=> (out_valid && !is_end && byte_count == $past(byte_count) + 16'd1))
        else $error("code point bytes broken apart");

    // Nothing is popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_stat.empty)
        else $error("job popped from an empty queue");

endmodule
